@@ design/ovp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ovp_pkg
// Shared types, mode and status codes, and widths for the orthogonal
// viewpoint datapath.
// ----------------------------------------------------------------------------
package ovp_pkg;

    localparam logic [2:0] MODE_X     = 3'd0;
    localparam logic [2:0] MODE_Y     = 3'd1;
    localparam logic [2:0] MODE_Z     = 3'd2;
    localparam logic [2:0] MODE_PITCH = 3'd3;
    localparam logic [2:0] MODE_ROLL  = 3'd4;
    localparam logic [2:0] MODE_YAW   = 3'd5;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_BADMODE = 2'd1;
    localparam logic [1:0] STAT_DEGEN   = 2'd2;
    localparam logic [1:0] STAT_SAT     = 2'd3;

    // root bits 32..0, quotient bits 40..0
    localparam int SQRT_BITS = 33;
    localparam int DIV_BITS  = 41;

    // 0.01 in Q16.16, rounded down
    localparam logic [32:0] NUDGE_RAW = 33'd655;
    localparam logic [40:0] QUO_CLAMP = 41'h100_0000_0000;

    typedef logic signed [32:0] diff_t;
    typedef logic [32:0]        root_t;
    typedef logic [65:0]        sumsq_t;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] m_x;
        logic signed [31:0] m_y;
        logic signed [31:0] m_z;
        diff_t              d_x;
        diff_t              d_y;
        diff_t              d_z;
        root_t              lxy;
        root_t              len;
    } ovp_item_t;

    function automatic logic [31:0] mag32(input diff_t d);
        logic [32:0] n;
        n = -d;
        return d[32] ? n[31:0] : d[31:0];
    endfunction

endpackage

@@ design/ovp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ovp_if
// Request and response channels: valid/ready with the point payload.
// ----------------------------------------------------------------------------
interface ovp_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         req_type;
    logic signed [31:0] cur_x;
    logic signed [31:0] cur_y;
    logic signed [31:0] cur_z;
    logic signed [31:0] mark_x;
    logic signed [31:0] mark_y;
    logic signed [31:0] mark_z;

    modport source (output valid, req_type, cur_x, cur_y, cur_z, mark_x, mark_y, mark_z,
                    input ready);
    modport sink (input valid, req_type, cur_x, cur_y, cur_z, mark_x, mark_y, mark_z,
                  output ready);
endinterface

interface ovp_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [1:0]         status;

    modport source (output valid, out_x, out_y, out_z, status, input ready);
    modport sink (input valid, out_x, out_y, out_z, status, output ready);
endinterface

@@ design/ovp_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ovp_front
// Takes request beats, forms the differences, their squares and the two
// floor square roots through a one-bit-per-stage root pipeline.
// ----------------------------------------------------------------------------
module ovp_front
    import ovp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    ovp_req_if.sink   req,
    output ovp_item_t item,
    output logic      item_valid,
    input  logic      item_ready
);

    logic               adv;
    logic               vld_a_reg;
    logic               vld_b_reg;
    logic [SQRT_BITS:0] vld_s_reg;

    ovp_item_t   pay_a_next;
    ovp_item_t   pay_a_reg;
    ovp_item_t   pay_b_reg;
    logic [63:0] sq_x_reg;
    logic [63:0] sq_y_reg;
    logic [63:0] sq_z_reg;

    ovp_item_t pay_s_reg    [0:SQRT_BITS];
    sumsq_t    rem_xy_reg   [0:SQRT_BITS];
    sumsq_t    rem_all_reg  [0:SQRT_BITS];
    root_t     root_xy_reg  [0:SQRT_BITS];
    root_t     root_all_reg [0:SQRT_BITS];

    // whole pipe moves together; it holds only when the last stage is stuck
    assign adv       = ~vld_s_reg[SQRT_BITS] | item_ready;
    assign req.ready = adv;

    always_comb
    begin
        pay_a_next      = '0;
        pay_a_next.mode = req.req_type;
        pay_a_next.m_x  = req.mark_x;
        pay_a_next.m_y  = req.mark_y;
        pay_a_next.m_z  = req.mark_z;
        pay_a_next.d_x  = diff_t'(req.cur_x) - diff_t'(req.mark_x);
        pay_a_next.d_y  = diff_t'(req.cur_y) - diff_t'(req.mark_y);
        pay_a_next.d_z  = diff_t'(req.cur_z) - diff_t'(req.mark_z);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_s_reg <= '0;
        end
        else if (adv)
        begin
            vld_a_reg <= req.valid;
            vld_b_reg <= vld_a_reg;
            vld_s_reg <= {vld_s_reg[SQRT_BITS-1:0], vld_b_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pay_a_reg       <= pay_a_next;
            pay_b_reg       <= pay_a_reg;
            sq_x_reg        <= {32'd0, mag32(pay_a_reg.d_x)} * {32'd0, mag32(pay_a_reg.d_x)};
            sq_y_reg        <= {32'd0, mag32(pay_a_reg.d_y)} * {32'd0, mag32(pay_a_reg.d_y)};
            sq_z_reg        <= {32'd0, mag32(pay_a_reg.d_z)} * {32'd0, mag32(pay_a_reg.d_z)};
            pay_s_reg[0]    <= pay_b_reg;
            rem_xy_reg[0]   <= {2'b00, sq_x_reg} + {2'b00, sq_y_reg};
            rem_all_reg[0]  <= {2'b00, sq_x_reg} + {2'b00, sq_y_reg} + {2'b00, sq_z_reg};
            root_xy_reg[0]  <= '0;
            root_all_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < SQRT_BITS; k++)
    begin : g_root
        localparam int B = SQRT_BITS - 1 - k;
        logic [67:0] try_xy;
        logic [67:0] try_all;
        logic        fit_xy;
        logic        fit_all;

        // (r + 2^B)^2 - r^2 against what is left of the sum
        assign try_xy  = ({35'd0, root_xy_reg[k]} << (B + 1)) + (68'd1 << (2 * B));
        assign try_all = ({35'd0, root_all_reg[k]} << (B + 1)) + (68'd1 << (2 * B));
        assign fit_xy  = {2'b00, rem_xy_reg[k]} >= try_xy;
        assign fit_all = {2'b00, rem_all_reg[k]} >= try_all;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                pay_s_reg[k+1]    <= pay_s_reg[k];
                rem_xy_reg[k+1]   <= fit_xy ? rem_xy_reg[k] - try_xy[65:0] : rem_xy_reg[k];
                rem_all_reg[k+1]  <= fit_all ? rem_all_reg[k] - try_all[65:0] : rem_all_reg[k];
                root_xy_reg[k+1]  <= fit_xy ? (root_xy_reg[k] | (root_t'(1) << B))
                                            : root_xy_reg[k];
                root_all_reg[k+1] <= fit_all ? (root_all_reg[k] | (root_t'(1) << B))
                                             : root_all_reg[k];
            end
        end
    end

    always_comb
    begin
        item     = pay_s_reg[SQRT_BITS];
        item.lxy = root_xy_reg[SQRT_BITS];
        item.len = root_all_reg[SQRT_BITS];
    end

    assign item_valid = vld_s_reg[SQRT_BITS];

endmodule

@@ design/ovp_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ovp_queue
// Small FIFO of items between the root and divide pipelines.
// ----------------------------------------------------------------------------
module ovp_queue
    import ovp_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  ovp_item_t in_item,
    input  logic      in_valid,
    output logic      in_ready,
    output ovp_item_t out_item,
    output logic      out_valid,
    input  logic      out_ready
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ovp_item_t       mem_reg [0:DEPTH-1];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            push;
    logic            pop;

    assign in_ready  = count_reg != CW'(DEPTH);
    assign out_valid = count_reg != '0;
    assign push      = in_valid & in_ready;
    assign pop       = out_valid & out_ready;
    assign out_item  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count above depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count missed a push");

    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !push |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count missed a pop");

endmodule

@@ design/ovp_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ovp_back
// Decodes the mode, scales the differences through three restoring
// dividers, places the new point and saturates it into the response.
// ----------------------------------------------------------------------------
module ovp_back
    import ovp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  ovp_item_t item,
    input  logic      item_valid,
    output logic      item_ready,
    ovp_rsp_if.source rsp
);

    localparam int LAST = DIV_BITS + 1;

    logic            adv;
    logic [LAST:0]   vld_d_reg;
    logic            out_vld_reg;

    logic [1:0]      stat_p;
    logic [32:0]     num_p;
    root_t           den_p;

    ovp_item_t       pay_d_reg  [0:LAST];
    logic [1:0]      stat_d_reg [0:LAST];
    root_t           den_d_reg  [0:LAST];
    logic [64:0]     rem_reg    [0:LAST][0:2];
    logic [DIV_BITS-1:0] quo_reg [0:LAST][0:2];
    logic            ovf_reg    [0:LAST][0:2];

    logic signed [31:0] out_x_reg;
    logic signed [31:0] out_y_reg;
    logic signed [31:0] out_z_reg;
    logic [1:0]         status_reg;

    assign adv        = ~out_vld_reg | rsp.ready;
    assign item_ready = adv;

    always_comb
    begin
        num_p = (item.mode == MODE_Z) ? item.len : NUDGE_RAW;
        den_p = (item.mode == MODE_Z) ? item.lxy : item.len;
        unique case (item.mode) inside
            MODE_X, MODE_Y, MODE_PITCH, MODE_ROLL:
                stat_p = STAT_OK;
            MODE_Z:
                stat_p = (item.lxy == '0) ? STAT_DEGEN : STAT_OK;
            MODE_YAW:
                stat_p = (item.len == '0) ? STAT_DEGEN : STAT_OK;
            default:
                stat_p = STAT_BADMODE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_d_reg   <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_d_reg   <= {vld_d_reg[LAST-1:0], item_valid};
            out_vld_reg <= vld_d_reg[LAST];
        end
    end

    // products stage: one 32x33 multiply per axis
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pay_d_reg[0]  <= item;
            stat_d_reg[0] <= stat_p;
            den_d_reg[0]  <= den_p;
            rem_reg[0][0] <= 65'(mag32(item.d_x)) * 65'(num_p);
            rem_reg[0][1] <= 65'(mag32(item.d_y)) * 65'(num_p);
            rem_reg[0][2] <= 65'(mag32(item.d_z)) * 65'(num_p);
            for (int a = 0; a < 3; a++)
            begin
                quo_reg[0][a] <= '0;
                ovf_reg[0][a] <= 1'b0;
            end
        end
    end

    // first divide stage only flags a quotient that reaches 2^41
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pay_d_reg[1]  <= pay_d_reg[0];
            stat_d_reg[1] <= stat_d_reg[0];
            den_d_reg[1]  <= den_d_reg[0];
            for (int a = 0; a < 3; a++)
            begin
                rem_reg[1][a] <= rem_reg[0][a];
                quo_reg[1][a] <= '0;
                ovf_reg[1][a] <= {9'd0, rem_reg[0][a]} >= {den_d_reg[0], 41'd0};
            end
        end
    end

    for (genvar s = 1; s <= DIV_BITS; s++)
    begin : g_div
        localparam int B = DIV_BITS - s;
        logic [73:0] dsh;
        logic [2:0]  fit;

        assign dsh = {41'd0, den_d_reg[s]} << B;
        for (genvar a = 0; a < 3; a++)
        begin : g_axis
            assign fit[a] = {9'd0, rem_reg[s][a]} >= dsh;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                pay_d_reg[s+1]  <= pay_d_reg[s];
                stat_d_reg[s+1] <= stat_d_reg[s];
                den_d_reg[s+1]  <= den_d_reg[s];
                for (int a = 0; a < 3; a++)
                begin
                    rem_reg[s+1][a] <= fit[a] ? rem_reg[s][a] - dsh[64:0] : rem_reg[s][a];
                    quo_reg[s+1][a] <= quo_reg[s][a] | (DIV_BITS'(fit[a]) << B);
                    ovf_reg[s+1][a] <= ovf_reg[s][a];
                end
            end
        end
    end

    function automatic logic signed [43:0] signed_mag(input logic [40:0] mg, input logic neg);
        logic signed [43:0] v;
        v = $signed({3'b000, mg});
        return neg ? -v : v;
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [43:0] v,
                                                   inout logic sat);
        logic signed [31:0] r;
        r = v[31:0];
        if (v > 44'sd2147483647)
        begin
            sat = 1'b1;
            r   = 32'sh7fff_ffff;
        end
        else if (v < -44'sd2147483648)
        begin
            sat = 1'b1;
            r   = 32'sh8000_0000;
        end
        return r;
    endfunction

    ovp_item_t          fin;
    logic [40:0]        sc   [0:2];
    logic signed [43:0] scs  [0:2];
    logic signed [43:0] off  [0:2];
    logic signed [31:0] res  [0:2];
    logic               sat;
    logic [1:0]         stat_f;

    always_comb
    begin
        fin = pay_d_reg[LAST];
        for (int a = 0; a < 3; a++)
        begin
            sc[a]  = (ovf_reg[LAST][a] || quo_reg[LAST][a] > QUO_CLAMP)
                     ? QUO_CLAMP : quo_reg[LAST][a];
            off[a] = '0;
        end
        scs[0] = signed_mag(sc[0], fin.d_x[32]);
        scs[1] = signed_mag(sc[1], fin.d_y[32]);
        scs[2] = signed_mag(sc[2], fin.d_z[32]);

        unique case (fin.mode) inside
            MODE_X:
            begin
                off[1] = signed_mag(41'(fin.lxy), fin.d_y[32]);
                off[2] = 44'(fin.d_z);
            end
            MODE_Y:
            begin
                off[0] = signed_mag(41'(fin.lxy), fin.d_x[32]);
                off[2] = 44'(fin.d_z);
            end
            MODE_Z:
            begin
                off[0] = scs[0];
                off[1] = scs[1];
            end
            MODE_PITCH:
                off[1] = signed_mag(41'(fin.len), fin.d_y[32]);
            MODE_ROLL:
                off[0] = signed_mag(41'(fin.len), fin.d_x[32]);
            MODE_YAW:
            begin
                off[0] = scs[0];
                off[1] = scs[1];
                off[2] = $signed({11'd0, fin.len}) + scs[2];
            end
            default:
                off[0] = '0;
        endcase

        sat    = 1'b0;
        res[0] = clamp32(44'(fin.m_x) + off[0], sat);
        res[1] = clamp32(44'(fin.m_y) + off[1], sat);
        res[2] = clamp32(44'(fin.m_z) + off[2], sat);

        stat_f = stat_d_reg[LAST];
        if (stat_f != STAT_OK)
        begin
            res[0] = fin.m_x;
            res[1] = fin.m_y;
            res[2] = fin.m_z;
        end
        else if (sat)
        begin
            stat_f = STAT_SAT;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_x_reg  <= res[0];
            out_y_reg  <= res[1];
            out_z_reg  <= res[2];
            status_reg <= stat_f;
        end
    end

    assign rsp.valid  = out_vld_reg;
    assign rsp.out_x  = out_x_reg;
    assign rsp.out_y  = out_y_reg;
    assign rsp.out_z  = out_z_reg;
    assign rsp.status = status_reg;

endmodule

@@ design/orthogonal_viewpoint_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orthogonal_viewpoint_unit
// Moves a viewer point onto the axis that suits a control mode, at the
// same distance from a marker point, with saturated Q16.16 results.
// ----------------------------------------------------------------------------
//   channel   dir   handshake      payload
//   req       in    valid/ready    req_type, cur_x/y/z, mark_x/y/z
//   rsp       out   valid/ready    out_x/y/z, status
//
// one beat accepted per cycle unless the root pipeline holds; a request runs
// through the 33-stage root pipeline, the queue and the 42-stage divider
// both pipelines advance as a whole and hold only when their last stage
// is stuck; the queue between them lets either side stall on its own
// reset clears all valid flags and queue pointers; no clearing pass
// ----------------------------------------------------------------------------
module orthogonal_viewpoint_unit
    import ovp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    ovp_req_if.sink   req,
    ovp_rsp_if.source rsp
);

    ovp_item_t front_item;
    logic      front_valid;
    logic      front_ready;
    ovp_item_t back_item;
    logic      back_valid;
    logic      back_ready;

    ovp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .item       (front_item),
        .item_valid (front_valid),
        .item_ready (front_ready)
    );

    ovp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (front_item),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .out_item  (back_item),
        .out_valid (back_valid),
        .out_ready (back_ready)
    );

    ovp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (back_item),
        .item_valid (back_valid),
        .item_ready (back_ready),
        .rsp        (rsp)
    );

endmodule
